[hdl/lmn_pkg.sv]
// Shared widths, codes and transfer payload types for the Lamport mutex node.
package lmn_pkg;

  localparam int CMD_W   = 3;
  localparam int SRC_W   = 4;
  localparam int MSG_W   = 32;
  localparam int KIND_W  = 3;
  localparam int DEST_W  = 4;
  localparam int QCNT_W  = 5;
  localparam int RANK_W  = 4;
  localparam int NCNT_W  = 5;
  localparam int REPLY_W = 5;

  localparam logic [REPLY_W-1:0] REPLY_MAX = 5'd31;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;
  localparam logic [CFG_INDEX_W-1:0] REG_MY_RANK    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NODE_COUNT = 1'd1;

  // event codes
  localparam logic [CMD_W-1:0] CMD_LOCK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UNLOCK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REREQ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REPLY   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd5;

  // outgoing message kinds
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REREQ   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REPLY   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [SRC_W-1:0] source;
    logic [MSG_W-1:0] msg_stamp;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] send_kind;
    logic [DEST_W-1:0] dest;
    logic [MSG_W-1:0]  send_stamp;
    logic              granted;
    logic [QCNT_W-1:0] queue_count;
    logic              not_found;
  } result_t;

endpackage

[hdl/lmn_if.sv]
// Valid/ready channel interfaces for event items and result items.
interface lmn_item_if import lmn_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lmn_result_if import lmn_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/lamport_mutex_node_core.sv]
// Lamport mutex node: event sequencer, timestamp table and sorted node queue.
// Insert: read each queue entry, then its stamp, and compare; shift later entries up; place.
//   removal: read and compare each entry, then shift later ones down (one-port queue walk).
// Throughput: one event at a time; the next is taken once the result is parked.
// Reset (rst, synchronous): clock, max_seen, table valid bits, queue length, counts cleared,
//   re-request flag set, my_rank 0, node_count 2; no clearing pass.
module lamport_mutex_node_core import lmn_pkg::*; #(
  parameter int MAX_NODES  = 16,
  parameter int STAMP_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  lmn_item_if.sink               in_if,
  lmn_result_if.source           out_if
);

  localparam int ID_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int LEN_W = $clog2(MAX_NODES + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_INS_RQ   = 4'd2;  // read queue entry
  localparam logic [3:0] S_INS_RS   = 4'd3;  // read its table stamp
  localparam logic [3:0] S_INS_CMP  = 4'd4;  // compare with new stamp
  localparam logic [3:0] S_SH_RD    = 4'd5;  // open a slot: read idx-1
  localparam logic [3:0] S_SH_WR    = 4'd6;  // open a slot: write idx
  localparam logic [3:0] S_INS_PUT  = 4'd7;
  localparam logic [3:0] S_RM_RD    = 4'd8;
  localparam logic [3:0] S_RM_CMP   = 4'd9;
  localparam logic [3:0] S_RMSH_RD  = 4'd10; // close the gap: read idx+1
  localparam logic [3:0] S_RMSH_WR  = 4'd11; // close the gap: write idx
  localparam logic [3:0] S_FINISH   = 4'd12;

  // node id = value mod MAX_NODES, by repeated subtract on a narrow value
  function automatic logic [ID_W-1:0] to_id(input logic [SRC_W-1:0] v);
    int t;
    t = int'(v);
    for (int k = 0; k < 8; k++) begin
      if (t >= MAX_NODES) t = t - MAX_NODES;
    end
    return ID_W'(t);
  endfunction

  function automatic logic [STAMP_BITS-1:0] stamp_inc(input logic [STAMP_BITS-1:0] v);
    return (v == '1) ? v : v + STAMP_BITS'(1);
  endfunction

  logic [3:0]              state;
  logic [CMD_W-1:0]        cmd_r;
  logic [ID_W-1:0]         id_r;
  logic [ID_W-1:0]         idx;
  logic [ID_W-1:0]         pos;
  logic [ID_W-1:0]         head;
  logic [STAMP_BITS-1:0]   ms_r;
  logic [STAMP_BITS-1:0]   key;
  logic [STAMP_BITS-1:0]   clock;
  logic [STAMP_BITS-1:0]   max_seen;
  logic [STAMP_BITS-1:0]   sstamp;
  logic [KIND_W-1:0]       kind;
  logic                    nf;
  logic [LEN_W-1:0]        len;
  logic [REPLY_W-1:0]      reply_count;
  logic                    needs_rerequest;
  logic [RANK_W-1:0]       my_rank;
  logic [NCNT_W-1:0]       node_count;
  logic                    out_valid;
  result_t                 out_data;

  // queue of node ids and per-node timestamp table
  logic [ID_W-1:0]         q_mem [MAX_NODES];
  logic [STAMP_BITS-1:0]   s_mem [MAX_NODES];
  logic [MAX_NODES-1:0]    s_valid;
  logic [ID_W-1:0]         q_rdata;
  logic [STAMP_BITS-1:0]   s_rdata;
  logic                    s_rvld;

  logic                    q_we;
  logic [ID_W-1:0]         q_waddr;
  logic [ID_W-1:0]         q_wdata;
  logic                    q_re;
  logic [ID_W-1:0]         q_raddr;
  logic                    s_we;
  logic [ID_W-1:0]         s_waddr;
  logic [STAMP_BITS-1:0]   s_wdata;
  logic                    s_re;

  logic [ID_W-1:0]         me;
  logic                    peer;
  logic [ID_W-1:0]         idx_m1;
  logic [ID_W-1:0]         idx_p1;
  logic [LEN_W-1:0]        len_m1;
  logic                    at_last;
  logic                    next_last;
  logic                    len_full;
  logic [STAMP_BITS-1:0]   cinc;
  logic [STAMP_BITS-1:0]   seen_max;
  logic [STAMP_BITS-1:0]   unlock_clock;
  logic [STAMP_BITS-1:0]   s_cur;
  logic                    granted;

  assign me           = to_id(my_rank);
  assign peer         = (id_r != me);
  assign idx_m1       = idx - ID_W'(1);
  assign idx_p1       = idx + ID_W'(1);
  assign len_m1       = len - LEN_W'(1);
  assign at_last      = (LEN_W'(idx) == len_m1);
  assign next_last    = (LEN_W'(idx_p1) == len_m1);
  assign len_full     = (len == LEN_W'(MAX_NODES));
  assign cinc         = stamp_inc(clock);
  assign seen_max     = (ms_r > max_seen) ? ms_r : max_seen;
  assign unlock_clock = (stamp_inc(max_seen) > clock) ? stamp_inc(max_seen) : clock;
  // a table entry never written reads as zero
  assign s_cur        = s_rvld ? s_rdata : '0;
  assign granted      = (len != '0) && (head == me) &&
                        ({1'b0, reply_count} + (REPLY_W+1)'(1) >= {1'b0, node_count});

  assign in_if.ready  = (state == S_IDLE);
  assign out_if.valid = out_valid;
  assign out_if.data  = out_data;

  // memory port control
  always_comb begin
    q_re    = 1'b0;
    q_raddr = idx;
    q_we    = 1'b0;
    q_waddr = idx;
    q_wdata = q_rdata;
    s_re    = 1'b0;
    s_we    = 1'b0;
    s_waddr = id_r;
    s_wdata = ms_r;
    case (state)
      S_INS_RQ, S_RM_RD: q_re = 1'b1;
      S_SH_RD: begin
        q_re    = 1'b1;
        q_raddr = idx_m1;
      end
      S_RMSH_RD: begin
        q_re    = 1'b1;
        q_raddr = idx_p1;
      end
      S_INS_RS: s_re = 1'b1;
      S_SH_WR, S_RMSH_WR: q_we = 1'b1;
      S_INS_PUT: begin
        q_we    = 1'b1;
        q_waddr = pos;
        q_wdata = id_r;
      end
      S_EXEC: begin
        if (cmd_r == CMD_LOCK) begin
          s_we    = 1'b1;
          s_waddr = me;
          s_wdata = cinc;
        end else if ((cmd_r == CMD_REQUEST || cmd_r == CMD_REREQ) && peer) begin
          s_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    if (q_re) q_rdata <= q_mem[q_raddr];
    if (s_we) s_mem[s_waddr] <= s_wdata;
    if (s_re) begin
      s_rdata <= s_mem[q_rdata];
      s_rvld  <= s_valid[q_rdata];
    end
    // shadow of the queue head for the grant check
    if (q_we && q_waddr == '0) head <= q_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= '0;
    end else if (s_we) begin
      s_valid[s_waddr] <= 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      my_rank    <= '0;
      node_count <= NCNT_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MY_RANK:    my_rank    <= cfg_data[RANK_W-1:0];
        REG_NODE_COUNT: node_count <= cfg_data[NCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // event sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      clock           <= '0;
      max_seen        <= '0;
      len             <= '0;
      reply_count     <= '0;
      needs_rerequest <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_if.valid) begin
            cmd_r  <= in_if.data.cmd;
            id_r   <= to_id(in_if.data.source);
            ms_r   <= STAMP_BITS'(in_if.data.msg_stamp);
            kind   <= KIND_NONE;
            sstamp <= '0;
            nf     <= 1'b0;
            state  <= S_EXEC;
          end
        end

        S_EXEC: begin
          case (cmd_r)
            CMD_LOCK: begin
              clock           <= cinc;
              key             <= cinc;
              id_r            <= me;
              kind            <= KIND_REQUEST;
              sstamp          <= cinc;
              reply_count     <= '0;
              needs_rerequest <= 1'b0;
              if (len_full) begin
                state <= S_FINISH;  // insert dropped on a full queue
              end else if (len == '0) begin
                pos   <= '0;
                state <= S_INS_PUT;
              end else begin
                idx   <= '0;
                state <= S_INS_RQ;
              end
            end
            CMD_UNLOCK: begin
              id_r   <= me;
              kind   <= KIND_RELEASE;
              sstamp <= clock;
              clock  <= unlock_clock;
              if (len == '0) begin
                nf    <= 1'b1;
                state <= S_FINISH;
              end else begin
                idx   <= '0;
                state <= S_RM_RD;
              end
            end
            CMD_REQUEST, CMD_REREQ: begin
              if (peer) begin
                max_seen <= seen_max;
                key      <= ms_r;
                kind     <= KIND_REPLY;
                sstamp   <= clock;
                if (cmd_r == CMD_REQUEST) begin
                  if (len_full) begin
                    state <= S_FINISH;
                  end else if (len == '0) begin
                    pos   <= '0;
                    state <= S_INS_PUT;
                  end else begin
                    idx   <= '0;
                    state <= S_INS_RQ;
                  end
                end else begin
                  state <= S_FINISH;
                end
              end else begin
                state <= S_FINISH;
              end
            end
            CMD_REPLY: begin
              state <= S_FINISH;
              if (peer) begin
                max_seen <= seen_max;
                if (ms_r > clock || (ms_r == clock && id_r < me)) begin
                  if (reply_count != REPLY_MAX) reply_count <= reply_count + REPLY_W'(1);
                end else begin
                  needs_rerequest <= 1'b1;
                end
              end
            end
            CMD_RELEASE: begin
              if (peer) begin
                max_seen <= seen_max;
                if (needs_rerequest) begin
                  kind            <= KIND_REREQ;
                  sstamp          <= clock;
                  needs_rerequest <= 1'b0;
                  reply_count     <= '0;
                end
                if (len == '0) begin
                  nf    <= 1'b1;
                  state <= S_FINISH;
                end else begin
                  idx   <= '0;
                  state <= S_RM_RD;
                end
              end else begin
                state <= S_FINISH;
              end
            end
            default: state <= S_FINISH;  // unused codes do nothing
          endcase
        end

        S_INS_RQ: state <= S_INS_RS;
        S_INS_RS: state <= S_INS_CMP;

        S_INS_CMP: begin
          // new entry goes before the first strictly later stamp
          if (s_cur > key) begin
            pos   <= idx;
            idx   <= ID_W'(len);
            state <= S_SH_RD;
          end else if (at_last) begin
            pos   <= ID_W'(len);
            state <= S_INS_PUT;
          end else begin
            idx   <= idx_p1;
            state <= S_INS_RQ;
          end
        end

        S_SH_RD: state <= S_SH_WR;

        S_SH_WR: begin
          if (idx_m1 == pos) begin
            state <= S_INS_PUT;
          end else begin
            idx   <= idx_m1;
            state <= S_SH_RD;
          end
        end

        S_INS_PUT: begin
          len   <= len + LEN_W'(1);
          state <= S_FINISH;
        end

        S_RM_RD: state <= S_RM_CMP;

        S_RM_CMP: begin
          if (q_rdata == id_r) begin
            if (at_last) begin
              len   <= len_m1;
              state <= S_FINISH;
            end else begin
              state <= S_RMSH_RD;
            end
          end else if (at_last) begin
            nf    <= 1'b1;
            state <= S_FINISH;
          end else begin
            idx   <= idx_p1;
            state <= S_RM_RD;
          end
        end

        S_RMSH_RD: state <= S_RMSH_WR;

        S_RMSH_WR: begin
          if (next_last) begin
            len   <= len_m1;
            state <= S_FINISH;
          end else begin
            idx   <= idx_p1;
            state <= S_RMSH_RD;
          end
        end

        S_FINISH: begin
          // park the result once the output register is free
          if (!out_valid || out_if.ready) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // output register valid: set when a result is parked, cleared on its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && (!out_valid || out_if.ready)) begin
      out_valid <= 1'b1;
    end else if (out_if.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, loaded with the transfer into the output register
  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!out_valid || out_if.ready)) begin
      out_data.send_kind   <= kind;
      out_data.dest        <= (kind == KIND_REPLY) ? DEST_W'(id_r) : '0;
      out_data.send_stamp  <= MSG_W'(sstamp);
      out_data.granted     <= granted;
      out_data.queue_count <= QCNT_W'(len);
      out_data.not_found   <= nf;
    end
  end

endmodule

[verif/tb_lamport_mutex_node_core.sv]
// Self-checking testbench for the Lamport mutex node core: random traffic, scoreboard check.
module tb_lamport_mutex_node_core;
  import lmn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PERIOD = 4;
  localparam int NODES = 16;
  localparam int SETTLE_CYCLES = 120;     // longer than the deepest queue walk
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int PHASE_EVENTS = 170;
  localparam int CHUNK_EVENTS = 50;

  // idling modes
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lmn_item_if ev_ch ();
  lmn_result_if res_ch ();

  lamport_mutex_node_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_if(ev_ch),
    .out_if(res_ch)
  );

  always #(PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Node mirror: configuration and protocol state as the block should hold it.
  // ---------------------------------------------------------------------------
  logic [RANK_W-1:0] my_rank;
  logic [NCNT_W-1:0] node_count;
  logic [MSG_W-1:0] lclock;
  logic [MSG_W-1:0] max_seen;
  logic [MSG_W-1:0] stamp_tbl [NODES];
  logic [SRC_W-1:0] order_q [NODES];
  int order_len;
  logic [REPLY_W-1:0] replies;
  bit rereq_due;

  // Event stream waiting for the driver, and results still owed by the block.
  item_t pending [$];
  result_t owed [$];

  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Stimulus shaping: stamps track the node clock unless the wide mode is on.
  logic [MSG_W-1:0] stamp_base;
  bit wide_stamps = 1'b0;
  int made = 0;

  function automatic logic [MSG_W-1:0] bump(logic [MSG_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Sorted insert: in front of the first strictly later stamp, so ties go behind.
  function automatic void enqueue_node(logic [SRC_W-1:0] id);
    int pos;
    pos = order_len;
    if (order_len >= NODES) return;     // full queue: insert is dropped
    for (int i = 0; i < order_len; i++) begin
      if (stamp_tbl[order_q[i]] > stamp_tbl[id]) begin
        pos = i;
        break;
      end
    end
    for (int i = order_len; i > pos; i--) order_q[i] = order_q[i-1];
    order_q[pos] = id;
    order_len++;
  endfunction

  function automatic bit dequeue_node(logic [SRC_W-1:0] id);
    for (int i = 0; i < order_len; i++) begin
      if (order_q[i] == id) begin
        for (int j = i; j + 1 < order_len; j++) order_q[j] = order_q[j+1];
        order_len--;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one event to the mirror and returns the result the block owes.
  function automatic result_t node_response(item_t ev);
    result_t r;
    logic [SRC_W-1:0] me;
    logic [SRC_W-1:0] src;
    logic [MSG_W-1:0] ms;
    logic [MSG_W-1:0] held;
    r = '0;
    me = my_rank;
    src = ev.source;
    ms = ev.msg_stamp;
    case (ev.cmd)
      CMD_LOCK: begin
        lclock = bump(lclock);
        stamp_tbl[me] = lclock;
        enqueue_node(me);
        r.send_kind = KIND_REQUEST;
        r.send_stamp = lclock;
        replies = '0;
        rereq_due = 1'b0;
      end
      CMD_UNLOCK: begin
        held = lclock;
        r.not_found = !dequeue_node(me);
        if (bump(max_seen) > lclock) lclock = bump(max_seen);
        r.send_kind = KIND_RELEASE;
        r.send_stamp = held;
      end
      CMD_REQUEST, CMD_REREQ, CMD_REPLY, CMD_RELEASE: begin
        // anything claiming to come from this node itself is dropped
        if (src != me) begin
          if (ms > max_seen) max_seen = ms;
          if (ev.cmd == CMD_REQUEST || ev.cmd == CMD_REREQ) begin
            stamp_tbl[src] = ms;
            if (ev.cmd == CMD_REQUEST) enqueue_node(src);
            r.send_kind = KIND_REPLY;
            r.dest = src;
            r.send_stamp = lclock;
          end else if (ev.cmd == CMD_REPLY) begin
            // a reply only counts if it is later than our request, or equal and from a lower rank
            if (ms > lclock || (ms == lclock && src < me)) begin
              if (replies != REPLY_MAX) replies++;
            end else begin
              rereq_due = 1'b1;
            end
          end else begin
            r.not_found = !dequeue_node(src);
            if (rereq_due) begin
              r.send_kind = KIND_REREQ;
              r.send_stamp = lclock;
              rereq_due = 1'b0;
              replies = '0;
            end
          end
        end
      end
      default: ;                          // unused codes: no effect
    endcase
    r.granted = (order_len > 0) && (order_q[0] == me) &&
                (int'(replies) + 1 >= int'(node_count));
    r.queue_count = order_len[QCNT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers pending events; each transfer is fed to the mirror.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      ev_ch.valid <= 1'b0;
      ev_ch.data <= '0;
    end else begin
      if (ev_ch.valid && ev_ch.ready) owed.push_back(node_response(ev_ch.data));
      if (!ev_ch.valid || ev_ch.ready) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          ev_ch.valid <= 1'b1;
          ev_ch.data <= pending.pop_front();
        end else begin
          ev_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, each result transfer against the oldest owed one.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [MSG_W-1:0] want, logic [MSG_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (owed.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result: expected none, actual %h", $time, got);
        end else begin
          want = owed.pop_front();
          check_field("send_kind", MSG_W'(want.send_kind), MSG_W'(got.send_kind));
          check_field("dest", MSG_W'(want.dest), MSG_W'(got.dest));
          check_field("send_stamp", want.send_stamp, got.send_stamp);
          check_field("granted", MSG_W'(want.granted), MSG_W'(got.granted));
          check_field("queue_count", MSG_W'(want.queue_count), MSG_W'(got.queue_count));
          check_field("not_found", MSG_W'(want.not_found), MSG_W'(got.not_found));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_event(logic [CMD_W-1:0] c, logic [SRC_W-1:0] s,
                                     logic [MSG_W-1:0] m);
    item_t ev;
    ev.cmd = c;
    ev.source = s;
    ev.msg_stamp = m;
    pending.push_back(ev);
    // ignored events do not count toward the stimulus budget
    if (c == CMD_LOCK || c == CMD_UNLOCK || (c <= CMD_RELEASE && s != my_rank)) made++;
  endfunction

  function automatic logic [SRC_W-1:0] pick_peer();
    logic [SRC_W-1:0] p;
    do p = SRC_W'($urandom_range(NODES - 1)); while (p == my_rank);
    return p;
  endfunction

  function automatic logic [MSG_W-1:0] next_stamp();
    if (wide_stamps) return $urandom;
    stamp_base = stamp_base + $urandom_range(2);
    return stamp_base + $urandom_range(6);
  endfunction

  // Wait until no event is queued or in transfer and no result is owed.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || ev_ch.valid || owed.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_MY_RANK) my_rank = val[RANK_W-1:0];
    else node_count = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drain, let the core settle, then reconfigure.
  task automatic reconfigure(int rank, int count);
    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    // upper data bit on a rank write is outside the field and must be ignored
    write_reg(REG_MY_RANK, {1'($urandom_range(1)), 4'(rank)});
    write_reg(REG_NODE_COUNT, 5'(count));
  endtask

  task automatic set_idling(int mode);
    send_idle_pct = (mode == IDLE_SEND) ? 87 : (mode == IDLE_BOTH) ? 16 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 87 : (mode == IDLE_BOTH) ? 16 : 0;
  endtask

  // One burst of protocol traffic, mostly well-formed rounds with random content.
  task automatic gen_chunk(int budget);
    int start;
    int kind;
    int k;
    logic [SRC_W-1:0] p;
    logic [SRC_W-1:0] flood_ids [$];
    start = made;
    while (made - start < budget) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        // local critical section: lock, replies, maybe a competing request, unlock
        push_event(CMD_LOCK, SRC_W'($urandom_range(NODES - 1)), $urandom);
        k = $urandom_range(int'(node_count) + 1);
        for (int i = 0; i < k; i++)
          push_event(CMD_REPLY, pick_peer(),
                     ($urandom_range(3) == 0) ? next_stamp() : next_stamp() + 20);
        if ($urandom_range(2) == 0) begin
          p = pick_peer();
          push_event(CMD_REQUEST, p, next_stamp());
          push_event(CMD_RELEASE, p, next_stamp());
        end
        push_event(CMD_UNLOCK, SRC_W'($urandom_range(NODES - 1)), $urandom);
      end else if (kind < 60) begin
        // remote critical section seen from here
        p = pick_peer();
        push_event(CMD_REQUEST, p, next_stamp());
        if ($urandom_range(1)) push_event(CMD_REREQ, p, next_stamp());
        push_event(CMD_RELEASE, p, next_stamp());
      end else if (kind < 66) begin
        // overfill the queue, then empty it again
        flood_ids.delete();
        for (int i = 0; i <= NODES; i++) begin
          p = pick_peer();
          flood_ids.push_back(p);
          push_event(CMD_REQUEST, p, next_stamp());
        end
        foreach (flood_ids[i]) push_event(CMD_RELEASE, flood_ids[i], next_stamp());
      end else if (kind < 70) begin
        // enough fresh replies to saturate the reply counter
        push_event(CMD_LOCK, SRC_W'($urandom_range(NODES - 1)), $urandom);
        for (int i = 0; i < 33; i++) push_event(CMD_REPLY, pick_peer(), next_stamp() + 1000);
        push_event(CMD_UNLOCK, SRC_W'($urandom_range(NODES - 1)), $urandom);
      end else begin
        // single stray event, unused codes and own-rank sources included
        push_event(CMD_W'($urandom_range(7)), SRC_W'($urandom_range(NODES - 1)),
                   next_stamp());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int rank_tbl [8];
    int count_tbl [8];
    int phase_start;

    rank_tbl = '{15, 7, 3, 0, 9, 15, 1, 12};
    count_tbl = '{16, 1, 0, 16, 5, 2, 3, 16};

    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    // mirror starts from the reset state
    my_rank = '0;
    node_count = 5'd2;
    lclock = '0;
    max_seen = '0;
    foreach (stamp_tbl[i]) stamp_tbl[i] = '0;
    foreach (order_q[i]) order_q[i] = '0;
    order_len = 0;
    replies = '0;
    rereq_due = 1'b1;
    stamp_base = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset configuration, every event kind and the corner cases.
    push_event(CMD_LOCK, 4'd0, 32'd0);
    push_event(CMD_REQUEST, 4'd1, 32'd0);           // earlier stamp goes in front
    push_event(CMD_REREQ, 4'd2, 32'd3);
    push_event(CMD_REPLY, 4'd1, 32'd5);
    push_event(CMD_REQUEST, 4'd0, 32'd9);           // own rank: dropped
    push_event(CMD_RELEASE, 4'd1, 32'd6);           // lock is now held
    push_event(3'd6, 4'd15, 32'hFFFF_FFFF);
    push_event(3'd7, 4'd10, 32'h5555_5555);
    push_event(CMD_UNLOCK, 4'd0, 32'd0);
    push_event(CMD_UNLOCK, 4'd0, 32'd0);            // nothing left to remove
    push_event(CMD_RELEASE, 4'd3, 32'd7);           // unknown node
    push_event(CMD_REPLY, 4'd1, 32'd0);             // stale reply
    push_event(CMD_RELEASE, 4'd1, 32'd8);           // triggers a re-request
    push_event(CMD_REQUEST, 4'd15, 32'd2);
    push_event(CMD_RELEASE, 4'd15, 32'd9);

    // single node: no replies needed
    reconfigure(15, 1);
    push_event(CMD_LOCK, 4'd3, 32'd0);
    wait_idle();
    // equal stamp from a lower rank still counts
    push_event(CMD_REPLY, 4'd3, lclock);
    push_event(CMD_REPLY, 4'd14, lclock);
    reconfigure(15, 0);
    push_event(CMD_UNLOCK, 4'd0, 32'd0);

    // Random phases, each with its own configuration and idling profile.
    // Every chunk ends with a full drain, so the sender regularly waits for
    // all owed results before going on.
    for (int ph = 0; ph < 8; ph++) begin
      reconfigure(rank_tbl[ph], count_tbl[ph]);
      set_idling(ph % 4);
      wide_stamps = (ph == 7);
      phase_start = made;
      while (made - phase_start < PHASE_EVENTS) begin
        stamp_base = (lclock > max_seen) ? lclock : max_seen;
        gen_chunk(CHUNK_EVENTS);
        wait_idle();
      end
    end

    // Directed: clock saturation at the top of the stamp range.
    set_idling(IDLE_NONE);
    reconfigure(15, 3);
    push_event(CMD_REREQ, 4'd2, 32'hFFFF_FFFF);
    push_event(CMD_UNLOCK, 4'd0, 32'd0);
    push_event(CMD_LOCK, 4'd0, 32'd0);
    push_event(CMD_REPLY, 4'd2, 32'hFFFF_FFFF);
    push_event(CMD_REPLY, 4'd4, 32'hFFFF_FFFF);
    push_event(CMD_UNLOCK, 4'd0, 32'd0);

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
